[sv/fepc_pkg.sv]
// ----------------------------------------------------------------------------
// fepc_pkg: shared types and constants
// Sizes, item kinds, controller states and the command and status bundles
// that join the controller and the datapath of the price cache.
// ----------------------------------------------------------------------------
`default_nettype none

package fepc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CODE_W  = 31;
  localparam int unsigned PRICE_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CHANGE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic insert;
    logic scan;
    logic hit_take;
    logic write_price;
    logic respond;
  } fepc_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              match;
    logic              exhausted;
    logic              out_free;
  } fepc_sts_t;

endpackage

`default_nettype wire

[sv/fepc_ctrl.sv]
// ----------------------------------------------------------------------------
// fepc_ctrl: item sequencer
// Accepts one item at a time, steps the datapath through insert or scan,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fepc_ctrl
  import fepc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire fepc_sts_t sts_i,
  output fepc_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts_i.kind)
          KIND_LOOKUP, KIND_CHANGE: state_d = ST_SCAN;
          default:                  state_d = ST_RESP;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.match || sts_i.exhausted) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.insert = (sts_i.kind == KIND_INSERT);
      end
      ST_SCAN: begin
        priority if (sts_i.match) begin
          cmd_o.hit_take    = 1'b1;
          cmd_o.write_price = (sts_i.kind == KIND_CHANGE);
        end else if (!sts_i.exhausted) begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_RESP: begin
        cmd_o.respond = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/fepc_dp.sv]
// ----------------------------------------------------------------------------
// fepc_dp: cache datapath
// Key and price memories in a ring, newest pointer and fill count, the
// newest-to-oldest scan with registered reads, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fepc_dp
  import fepc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fepc_cmd_t          cmd_i,
  output fepc_sts_t               sts_o,
  input  wire logic [KIND_W-1:0]  kind_i,
  input  wire logic [CODE_W-1:0]  item_code_i,
  input  wire logic [PRICE_W-1:0] price_cents_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    hit_o,
  output logic [PRICE_W-1:0]      price_out_o,
  output logic                    is_full_o,
  output logic                    is_empty_o
);

  logic [CODE_W-1:0]  key_mem   [ENTRIES];
  logic [PRICE_W-1:0] price_mem [ENTRIES];

  logic [KIND_W-1:0]  kind_q;
  logic [CODE_W-1:0]  code_q;
  logic [PRICE_W-1:0] price_q;

  logic [IDX_W-1:0] newest_q, newest_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] age_q, age_d;
  logic             rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0] rd_slot_q;
  logic [CODE_W-1:0]  key_rd_q;
  logic [PRICE_W-1:0] price_rd_q;

  logic               hit_q;
  logic [PRICE_W-1:0] price_res_q;

  logic               out_valid_q, out_valid_d;
  logic               out_hit_q;
  logic [PRICE_W-1:0] out_price_q;
  logic               out_full_q;
  logic               out_empty_q;

  logic [IDX_W-1:0] ins_slot;
  logic [IDX_W-1:0] age_idx;
  logic [IDX_W:0]   wrap_sum;
  logic [IDX_W-1:0] rd_addr;
  logic             issue;
  logic             full;

  assign full     = (count_q == CNT_W'(ENTRIES));
  assign ins_slot = (newest_q == IDX_W'(ENTRIES - 1)) ? '0 : newest_q + 1'b1;

  // slot of the entry age_q inserts older than the newest
  assign age_idx  = age_q[IDX_W-1:0];
  assign wrap_sum = {1'b0, newest_q} + (IDX_W+1)'(ENTRIES) - {1'b0, age_idx};
  assign rd_addr  = (newest_q >= age_idx) ? (newest_q - age_idx) : wrap_sum[IDX_W-1:0];
  assign issue    = cmd_i.scan && (age_q < count_q);

  always_comb begin
    newest_d = newest_q;
    count_d  = count_q;
    if (cmd_i.insert) begin
      newest_d = ins_slot;
      if (!full) count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    age_d      = age_q;
    rd_valid_d = issue;
    if (cmd_i.load) begin
      age_d = '0;
    end else if (issue) begin
      age_d = age_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.respond) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q    <= '0;
      count_q     <= '0;
      age_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      newest_q    <= newest_d;
      count_q     <= count_d;
      age_q       <= age_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= kind_i;
      code_q      <= item_code_i;
      price_q     <= price_cents_i;
      hit_q       <= 1'b0;
      price_res_q <= '0;
    end else if (cmd_i.hit_take) begin
      hit_q <= 1'b1;
      if (kind_q == KIND_LOOKUP) price_res_q <= price_rd_q;
    end
    if (issue) rd_slot_q <= rd_addr;
  end

  // memories: one write port each, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) key_mem[ins_slot] <= code_q;
    if (cmd_i.scan) key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      price_mem[ins_slot] <= price_q;
    end else if (cmd_i.write_price) begin
      price_mem[rd_slot_q] <= price_q;
    end
    if (cmd_i.scan) price_rd_q <= price_mem[rd_addr];
  end

  // output register, count already reflects this item
  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      out_hit_q   <= hit_q;
      out_price_q <= price_res_q;
      out_full_q  <= full;
      out_empty_q <= (count_q == '0);
    end
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.match     = rd_valid_q && (key_rd_q == code_q);
  assign sts_o.exhausted = (age_q >= count_q) && !rd_valid_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign price_out_o = out_price_q;
  assign is_full_o   = out_full_q;
  assign is_empty_o  = out_empty_q;

endmodule

`default_nettype wire

[sv/fifo_evict_price_cache.sv]
// ----------------------------------------------------------------------------
// fifo_evict_price_cache: key-to-price cache with oldest-first eviction
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  kind_i, item_code_i, price_cents_i
//   out      output     out_valid_o/out_stall_i hit_o, price_out_o, is_full_o,
//                                               is_empty_o
//
// insert and unused kinds go straight to the result; a lookup or change
// scans the key memory newest to oldest, one read per cycle, up to and
// including the match, or through all entries held on a miss.
// one item is worked at a time; a new item is taken while a result waits.
// reset clears pointer, fill count and handshake state; memories need none.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_evict_price_cache
  import fepc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [KIND_W-1:0]  kind_i,
  input  wire logic [CODE_W-1:0]  item_code_i,
  input  wire logic [PRICE_W-1:0] price_cents_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    hit_o,
  output logic [PRICE_W-1:0]      price_out_o,
  output logic                    is_full_o,
  output logic                    is_empty_o
);

  fepc_cmd_t cmd;
  fepc_sts_t sts;

  fepc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fepc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (kind_i),
    .item_code_i   (item_code_i),
    .price_cents_i (price_cents_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .price_out_o   (price_out_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after accept");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o))
    else $error("cache reported full and empty at once");

  a_miss_price_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (price_out_o == '0))
    else $error("nonzero price on a miss");
`endif

endmodule

`default_nettype wire

[sim/fifo_evict_price_cache_tb.sv]
// ----------------------------------------------------------------------------
// fifo_evict_price_cache_tb: self-checking bench for the price cache
// Walks a short table of directed items (empty cache, extreme codes and
// prices, duplicates, fill and eviction, the unused kind), then random items
// weighted toward codes already held. Results are checked against the table or
// a local model of the cache ring, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module fifo_evict_price_cache_tb;
  import fepc_pkg::*;

  localparam logic [KIND_W-1:0]  KIND_UNUSED   = 2'd3;
  localparam logic [CODE_W-1:0]  CODE_MAX      = '1;
  localparam logic [PRICE_W-1:0] PRICE_MAX     = '1;
  localparam int unsigned        RANDOM_ITEMS  = 1280;
  localparam int unsigned        CHUNK_ITEMS   = 100;
  localparam int unsigned        HOLD_CYCLES   = 150;
  localparam int unsigned        SETTLE_CYCLES = 4 + ENTRIES + 8;
  localparam int unsigned        CYCLE_LIMIT   = 400000;
  localparam int unsigned        REPORT_MAX    = 10;

  typedef struct packed {
    logic               hit;
    logic [PRICE_W-1:0] price;
    logic               full;
    logic               empty;
  } reply_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [CODE_W-1:0]  code;
    logic [PRICE_W-1:0] price;
    int unsigned        rep;
    bit                 typed;
    reply_t             want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i        = '0;
  logic [CODE_W-1:0]  item_code_i   = '0;
  logic [PRICE_W-1:0] price_cents_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               hit_o;
  logic [PRICE_W-1:0] price_out_o;
  logic               is_full_o;
  logic               is_empty_o;

  // model of the cache ring
  logic [CODE_W-1:0]  key_mem  [ENTRIES];
  logic [PRICE_W-1:0] cost_mem [ENTRIES];
  int unsigned        newest_idx;
  int unsigned        held_cnt;

  reply_t      pending_replies [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned hold_cycles  = 0;
  bit          idle_on      = 1'b1;

  fifo_evict_price_cache u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .item_code_i   (item_code_i),
    .price_cents_i (price_cents_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .price_out_o   (price_out_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic reply_t reply(input logic hit, input logic [PRICE_W-1:0] price,
                                   input logic full, input logic empty);
    reply_t r;
    r.hit   = hit;
    r.price = price;
    r.full  = full;
    r.empty = empty;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input logic [KIND_W-1:0] kind,
                                       input logic [CODE_W-1:0] code,
                                       input logic [PRICE_W-1:0] price,
                                       input int unsigned rep, input bit typed,
                                       input reply_t want);
    dir_row_t r;
    r.kind  = kind;
    r.code  = code;
    r.price = price;
    r.rep   = rep;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // applies one item to the model ring and returns the result it gives
  function automatic reply_t cache_step(input logic [KIND_W-1:0] kind,
                                        input logic [CODE_W-1:0] code,
                                        input logic [PRICE_W-1:0] price);
    reply_t      r;
    bit          found;
    int unsigned s;
    int unsigned slot;
    r     = '0;
    found = 1'b0;
    slot  = 0;
    if (kind == KIND_INSERT) begin
      newest_idx           = (newest_idx + 1) % ENTRIES;
      key_mem[newest_idx]  = code;
      cost_mem[newest_idx] = price;
      if (held_cnt < ENTRIES) held_cnt++;
    end else if (kind == KIND_LOOKUP || kind == KIND_CHANGE) begin
      // newest to oldest, first match wins
      for (int unsigned age = 0; age < held_cnt && !found; age++) begin
        s = (newest_idx + ENTRIES - age) % ENTRIES;
        if (key_mem[s] == code) begin
          found = 1'b1;
          slot  = s;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        if (kind == KIND_LOOKUP) r.price = cost_mem[slot];
        else cost_mem[slot] = price;
      end
    end
    r.full  = (held_cnt == ENTRIES);
    r.empty = (held_cnt == 0);
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned sel;
    logic [31:0] raw;
    sel = $urandom_range(0, 9);
    raw = $urandom;
    if (sel < 4 && held_cnt != 0)
      return key_mem[(newest_idx + ENTRIES - $urandom_range(0, held_cnt - 1)) % ENTRIES];
    if (sel < 7) return CODE_W'($urandom_range(0, 7));
    if (sel == 7) return CODE_MAX - CODE_W'($urandom_range(0, 2));
    return raw[CODE_W-1:0];
  endfunction

  function automatic logic [PRICE_W-1:0] pick_price();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return PRICE_MAX;
    return $urandom;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                           input logic [PRICE_W-1:0] price, input bit typed,
                           input reply_t want);
    int unsigned gap;
    reply_t      model_reply;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    item_code_i   <= code;
    price_cents_i <= price;
    do @(posedge clk_i); while (in_stall_o);
    model_reply = cache_step(kind, code, price);
    pending_replies.push_back(typed ? want : model_reply);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_all_replies();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_fault(input string what, input reply_t want, input reply_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("%s: exp hit=%0b price=%0d full=%0b empty=%0b, got hit=%0b price=%0d full=%0b empty=%0b",
               what, want.hit, want.price, want.full, want.empty,
               got.hit, got.price, got.full, got.empty);
  endtask

  // result side: random stall per item, long hold-off on request
  initial begin : result_side
    int unsigned n;
    reply_t      got;
    reply_t      want;
    forever begin
      if (hold_cycles != 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
      got = {hit_o, price_out_o, is_full_o, is_empty_o};
      if (pending_replies.size() == 0) begin
        report_fault("unexpected result", '0, got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) report_fault("mismatch", want, got);
      end
    end
  end

  initial begin : item_side
    dir_row_t    rows [$];
    dir_row_t    r;
    int unsigned k;
    logic [KIND_W-1:0] kind;

    for (int unsigned e = 0; e < ENTRIES; e++) begin
      key_mem[e]  = '0;
      cost_mem[e] = '0;
    end
    newest_idx = 0;
    held_cnt   = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty cache, extremes, duplicates, fill, eviction, unused kind
    rows.push_back(dir_row(KIND_LOOKUP, '0, '0, 1, 1, reply(0, '0, 0, 1)));
    rows.push_back(dir_row(KIND_CHANGE, 31'd5, PRICE_MAX, 1, 1, reply(0, '0, 0, 1)));
    rows.push_back(dir_row(KIND_UNUSED, CODE_MAX, PRICE_MAX, 1, 1, reply(0, '0, 0, 1)));
    rows.push_back(dir_row(KIND_INSERT, CODE_MAX, PRICE_MAX, 1, 1, reply(0, '0, 0, 0)));
    rows.push_back(dir_row(KIND_LOOKUP, CODE_MAX, '0, 1, 1, reply(1, PRICE_MAX, 0, 0)));
    rows.push_back(dir_row(KIND_INSERT, '0, '0, 1, 1, reply(0, '0, 0, 0)));
    rows.push_back(dir_row(KIND_LOOKUP, '0, PRICE_MAX, 1, 1, reply(1, '0, 0, 0)));
    rows.push_back(dir_row(KIND_CHANGE, CODE_MAX, 32'h1234_5678, 1, 1, reply(1, '0, 0, 0)));
    rows.push_back(dir_row(KIND_LOOKUP, CODE_MAX, '0, 1, 0, '0));
    rows.push_back(dir_row(KIND_INSERT, '0, 32'd7, 1, 0, '0));
    rows.push_back(dir_row(KIND_LOOKUP, '0, '0, 1, 0, '0));
    rows.push_back(dir_row(KIND_INSERT, 31'd100, 32'h8000_0001, ENTRIES - 3, 0, '0));
    rows.push_back(dir_row(KIND_INSERT, 31'd200, 32'd42, 1, 0, '0));
    rows.push_back(dir_row(KIND_LOOKUP, CODE_MAX, '0, 1, 0, '0));
    rows.push_back(dir_row(KIND_LOOKUP, 31'd100, '0, 1, 0, '0));
    rows.push_back(dir_row(KIND_UNUSED, 31'd200, '0, 1, 0, '0));

    foreach (rows[i]) begin
      r = rows[i];
      for (int unsigned j = 0; j < r.rep; j++)
        send_item(r.kind, r.code + CODE_W'(j), r.price, r.typed, r.want);
    end
    wait_all_replies();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % CHUNK_ITEMS == 0) idle_on = ($urandom_range(0, 3) != 0);
      // long hold-off on the result side while items keep coming
      if (i == 4 * CHUNK_ITEMS) hold_cycles = HOLD_CYCLES;
      if (i == 8 * CHUNK_ITEMS) wait_all_replies();
      k = $urandom_range(0, 19);
      if (k < 8) kind = KIND_INSERT;
      else if (k < 15) kind = KIND_LOOKUP;
      else if (k < 19) kind = KIND_CHANGE;
      else kind = KIND_UNUSED;
      send_item(kind, pick_code(), pick_price(), 0, '0);
    end

    wait_all_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
